// ===== hdl/jms_pkg.sv =====
// ----------------------------------------------------------------------------
// jms_pkg: shared definitions for the joint motion simulator
// Sizes, operation codes, beat formats and the joint record layout.
// ----------------------------------------------------------------------------
package jms_pkg;

  localparam int NUM_JOINTS = 4;
  localparam int FRAC_BITS  = 16;

  localparam int JIDX_W  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int DT_W    = FRAC_BITS + 1;
  localparam int ELX_W   = (DT_W > 17) ? DT_W : 17;
  localparam int ACC_W   = 35;
  localparam int MULA_W  = 33;
  localparam int PROD_W  = MULA_W + DT_W + 1;

  localparam logic [ELX_W-1:0] ONE_SECOND = ELX_W'(1) << FRAC_BITS;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_POS  = 3'd1;
  localparam logic [2:0] OP_VEL  = 3'd2;
  localparam logic [2:0] OP_MODE = 3'd3;
  localparam logic [2:0] OP_REQ  = 3'd4;
  localparam logic [2:0] OP_TICK = 3'd5;

  localparam logic [7:0] REQ_POSITION = 8'd0;
  localparam logic [7:0] REQ_MODE     = 8'd1;

  localparam logic [1:0] CFG_VEL_CODE  = 2'd0;
  localparam logic [1:0] CFG_POS_CODE  = 2'd1;
  localparam logic [1:0] CFG_STBY_CODE = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         joint_slot;
    logic [7:0]         dev_id;
    logic signed [31:0] value;
    logic               value_valid;
    logic [7:0]         mode_value;
    logic signed [31:0] limit_min;
    logic signed [31:0] limit_max;
    logic [30:0]        slew_speed;
    logic [16:0]        elapsed;
    logic [7:0]         request_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         answer_device;
    logic               answer_kind;
    logic signed [31:0] answer_position;
    logic [7:0]         answer_mode;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         device;
    logic signed [31:0] low_limit;
    logic signed [31:0] high_limit;
    logic [30:0]        speed;
    logic signed [31:0] position;
    logic signed [31:0] target;
    logic signed [31:0] velocity;
    logic [7:0]         mode;
  } joint_rec_t;

  typedef struct packed {
    logic              load;
    logic              pos_we;
    logic              tgt_we;
    logic              vel_we;
    logic              mode_we;
    logic [JIDX_W-1:0] idx;
    joint_rec_t        rec;
  } tbl_wr_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic sum_sub;
    logic clamp_cmd;
  } arith_ctl_t;

endpackage

// ===== hdl/jms_table.sv =====
// ----------------------------------------------------------------------------
// jms_table: joint record store
// Flip-flop records with one write port and one read index; in-use flags reset.
// ----------------------------------------------------------------------------
module jms_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jms_pkg::tbl_wr_t           wr,
  input  logic [jms_pkg::JIDX_W-1:0] rd_idx,
  output jms_pkg::joint_rec_t        rd_rec,
  output logic                       rd_used
);
  import jms_pkg::*;

  joint_rec_t rec_r  [NUM_JOINTS];
  logic       used_r [NUM_JOINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_JOINTS; i++) used_r[i] <= 1'b0;
    end else if (wr.load) begin
      used_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.load) begin
      rec_r[wr.idx] <= wr.rec;
    end else begin
      if (wr.pos_we)  rec_r[wr.idx].position <= wr.rec.position;
      if (wr.tgt_we)  rec_r[wr.idx].target   <= wr.rec.target;
      if (wr.vel_we)  rec_r[wr.idx].velocity <= wr.rec.velocity;
      if (wr.mode_we) rec_r[wr.idx].mode     <= wr.rec.mode;
    end
  end

  assign rd_rec  = rec_r[rd_idx];
  assign rd_used = used_r[rd_idx];

endmodule

// ===== hdl/jms_arith.sv =====
// ----------------------------------------------------------------------------
// jms_arith: shared multiply, add and clamp unit
// Registered product, registered sum, and the clamp and slew results.
// ----------------------------------------------------------------------------
module jms_arith (
  input  logic                             clk,
  input  jms_pkg::arith_ctl_t              ctl,
  input  logic signed [jms_pkg::MULA_W-1:0] mul_a,
  input  logic [jms_pkg::DT_W-1:0]         dt,
  input  jms_pkg::joint_rec_t              rec,
  input  logic signed [31:0]               cmd_value,
  output logic signed [31:0]               clamp_q,
  output logic signed [31:0]               slew_q
);
  import jms_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  step;

  // Floor of the product scaled back to the fixed-point grid.
  assign step = ACC_W'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) prod_r <= mul_a * $signed({1'b0, dt});
    if (ctl.sum_en) begin
      if (ctl.sum_sub) acc_r <= ACC_W'(rec.target) - ACC_W'(rec.position);
      else             acc_r <= ACC_W'(rec.position) + step;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] cin;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] v;
    cin = ctl.clamp_cmd ? ACC_W'(cmd_value) : acc_r;
    lo  = ACC_W'(rec.low_limit);
    hi  = ACC_W'(rec.high_limit);
    v   = (cin < lo) ? lo : cin;
    v   = (v > hi) ? hi : v;
    clamp_q = v[31:0];
  end

  always_comb begin
    logic signed [ACC_W-1:0] mag;
    logic signed [ACC_W-1:0] moved;
    mag   = acc_r[ACC_W-1] ? -acc_r : acc_r;
    moved = acc_r[ACC_W-1] ? ACC_W'(rec.position) - step : ACC_W'(rec.position) + step;
    slew_q = (mag <= step) ? rec.target : moved[31:0];
  end

endmodule

// ===== hdl/joint_motion_simulator.sv =====
// ----------------------------------------------------------------------------
// joint_motion_simulator: table of simulated actuator joints
// Loads joints, applies commands, answers requests and advances time.
// ----------------------------------------------------------------------------
// Use: command beats arrive on in_valid / in_stall / in_data. A beat is taken
// when in_valid is high and in_stall is low; in_stall is high for as long as
// an earlier beat is still being worked on, so one beat is handled at a time.
// Answers leave on out_valid / out_stall / out_data from an output register;
// the next input beat may be taken while an answer still waits there.
// A load or a dropped beat is handled at once in the idle state. A command
// or a request walks the table one slot per cycle while looking for the
// device id, starting from slot 0, and then acts on the joint it finds; a
// request then places its answer in the output register. A tick steps over
// idle slots and passes each joint in use in turn through the one shared
// multiplier and then the one shared adder and clamp.
// Configuration writes on cfg_valid / cfg_index / cfg_data are always taken
// (cfg_ready is tied high); indexes beyond the register list are ignored.
// Reset (rst_n low, synchronous) marks every slot free, restores the mode
// codes and empties the output register. If the receiver stalls, an answer
// waits in the output register and a later request waits in its final step.
// ----------------------------------------------------------------------------
module joint_motion_simulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jms_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jms_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import jms_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_CMD  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_TMUL = 3'd4;
  localparam logic [2:0] S_TSUM = 3'd5;
  localparam logic [2:0] S_TUPD = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [JIDX_W-1:0] idx_r, idx_nxt;
  in_item_t          item_r;
  logic [DT_W-1:0]   dt_r;
  logic [7:0]        vel_code_r, pos_code_r, stby_code_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  tbl_wr_t             wr;
  joint_rec_t          rec;
  logic                used;
  arith_ctl_t          ctl;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [31:0]  clamp_q;
  logic signed [31:0]  slew_q;

  logic              accept;
  logic              last;
  logic              is_vel;
  logic              out_free;
  logic [ELX_W-1:0]  el_ext;
  logic [DT_W-1:0]   dt_in;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign last     = (idx_r == JIDX_W'(NUM_JOINTS - 1));
  assign is_vel   = (rec.mode == vel_code_r);
  assign out_free = !out_valid_r || !out_stall;

  // Elapsed time saturates at one second.
  assign el_ext = ELX_W'(in_data.elapsed);
  assign dt_in  = (el_ext > ONE_SECOND) ? DT_W'(ONE_SECOND) : DT_W'(el_ext);

  // Velocity is signed; slew speed is a magnitude.
  assign mul_a = is_vel ? MULA_W'(rec.velocity) : $signed({2'b00, rec.speed});

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_code_r  <= 8'd2;
      pos_code_r  <= 8'd1;
      stby_code_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VEL_CODE:  vel_code_r  <= cfg_data;
        CFG_POS_CODE:  pos_code_r  <= cfg_data;
        CFG_STBY_CODE: stby_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: decides the next step, drives the table write port and the
  // shared arithmetic unit.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr            = '0;
    wr.idx        = idx_r;
    ctl           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_data.opcode == OP_LOAD) begin
            // A load acts at once on the slot it names.
            wr.load              = (int'(in_data.joint_slot) < NUM_JOINTS);
            wr.idx               = JIDX_W'(in_data.joint_slot);
            wr.rec.device        = in_data.dev_id;
            wr.rec.low_limit     = in_data.limit_min;
            wr.rec.high_limit    = in_data.limit_max;
            wr.rec.speed         = in_data.slew_speed;
            wr.rec.position      = in_data.value;
            wr.rec.target        = in_data.value;
            wr.rec.velocity      = '0;
            wr.rec.mode          = stby_code_r;
          end else if (in_data.opcode == OP_TICK) begin
            if (dt_in != '0) state_nxt = S_TMUL;
          end else if ((in_data.opcode inside {OP_POS, OP_VEL, OP_MODE, OP_REQ}) &&
                       in_data.value_valid) begin
            // Requests for fields other than position or mode give nothing.
            if (in_data.opcode != OP_REQ || in_data.request_code == REQ_POSITION ||
                in_data.request_code == REQ_MODE) begin
              state_nxt = S_FIND;
            end
          end
        end
      end

      S_FIND: begin
        if (used && rec.device == item_r.dev_id) begin
          state_nxt = S_CMD;
        end else if (last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_CMD: begin
        ctl.clamp_cmd = 1'b1;
        state_nxt     = S_IDLE;
        case (item_r.opcode)
          OP_POS: begin
            wr.tgt_we       = 1'b1;
            wr.vel_we       = 1'b1;
            wr.mode_we      = 1'b1;
            wr.rec.target   = clamp_q;
            wr.rec.velocity = '0;
            wr.rec.mode     = pos_code_r;
          end
          OP_VEL: begin
            wr.vel_we       = 1'b1;
            wr.mode_we      = 1'b1;
            wr.rec.velocity = item_r.value;
            wr.rec.mode     = vel_code_r;
          end
          OP_MODE: begin
            wr.tgt_we       = 1'b1;
            wr.vel_we       = 1'b1;
            wr.mode_we      = 1'b1;
            wr.rec.target   = rec.position;
            wr.rec.velocity = '0;
            wr.rec.mode     = item_r.mode_value;
          end
          OP_REQ: state_nxt = S_OUT;
          default: ;
        endcase
      end

      S_OUT: begin
        // Hold here until the output register can take the answer.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.answer_device = rec.device;
          out_data_nxt.answer_kind   = (item_r.request_code == REQ_MODE);
          out_data_nxt.answer_position =
            (item_r.request_code == REQ_POSITION) ? rec.position : '0;
          out_data_nxt.answer_mode =
            (item_r.request_code == REQ_MODE) ? rec.mode : '0;
          state_nxt = S_IDLE;
        end
      end

      S_TMUL: begin
        if (used) begin
          ctl.mul_en = 1'b1;
          state_nxt  = S_TSUM;
        end else if (last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_TSUM: begin
        // Velocity joints add the scaled step; others form the error to target.
        ctl.sum_en  = 1'b1;
        ctl.sum_sub = !is_vel;
        state_nxt   = S_TUPD;
      end

      S_TUPD: begin
        wr.pos_we       = 1'b1;
        wr.tgt_we       = is_vel;
        wr.rec.position = is_vel ? clamp_q : slew_q;
        wr.rec.target   = clamp_q;
        if (last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TMUL;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      item_r <= in_data;
      dt_r   <= dt_in;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  jms_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_idx  (idx_r),
    .rd_rec  (rec),
    .rd_used (used)
  );

  jms_arith u_arith (
    .clk       (clk),
    .ctl       (ctl),
    .mul_a     (mul_a),
    .dt        (dt_r),
    .rec       (rec),
    .cmd_value (item_r.value),
    .clamp_q   (clamp_q),
    .slew_q    (slew_q)
  );

endmodule

// ===== test/joint_motion_simulator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joint_motion_simulator_test: self-checking bench for the joint simulator
// Drives command beats into the joint table, predicts every answer with a
// behavioural copy of the joints and compares answers field by field.
// ----------------------------------------------------------------------------
module joint_motion_simulator_test;
  import jms_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 11;
  // A tick with every slot in use is the slowest beat.
  localparam int SETTLE_CYCLES  = 3 * NUM_JOINTS + 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;
  localparam int MAX_GAP        = 40;

  // Opcodes that the block must ignore, and a register index with no register.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam int                 Q_ONE     = 1 << FRAC_BITS;
  localparam int                 Q_HUNDRED = 100 * Q_ONE;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  // Idling percentages for the sender and the receiver.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int error_count = 0;
  int quiet_cycles = 0;

  // Answers the joint model has produced and the block has yet to deliver.
  out_item_t pending_answers[$];
  out_item_t expected_answer;

  // Behavioural copy of the joint table and the mode code registers.
  logic              sim_used  [NUM_JOINTS];
  logic [7:0]        sim_dev   [NUM_JOINTS];
  logic signed [31:0] sim_lo   [NUM_JOINTS];
  logic signed [31:0] sim_hi   [NUM_JOINTS];
  logic [30:0]       sim_speed [NUM_JOINTS];
  logic signed [31:0] sim_pos  [NUM_JOINTS];
  logic signed [31:0] sim_tgt  [NUM_JOINTS];
  logic signed [31:0] sim_vel  [NUM_JOINTS];
  logic [7:0]        sim_mode  [NUM_JOINTS];
  logic [7:0]        code_velocity = 8'd2;
  logic [7:0]        code_position = 8'd1;
  logic [7:0]        code_standby  = 8'd0;

  // Device ids that random beats mostly address, so that commands find joints.
  logic [7:0] id_pool [6];

  joint_motion_simulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      sim_used[j] = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Joint model
  // --------------------------------------------------------------------------

  // Raise to the low limit first, then lower to the high limit, so that the
  // high limit wins when the two are crossed.
  function automatic longint clamp_to_limits(input longint v, input int j);
    if (v < longint'(sim_lo[j])) v = sim_lo[j];
    if (v > longint'(sim_hi[j])) v = sim_hi[j];
    return v;
  endfunction

  // Applies one accepted beat to the joint model and queues any answer it
  // gives.
  function automatic void simulate_joint_item(input in_item_t it);
    int        hit;
    int        j;
    longint    dt;
    longint    p;
    longint    step;
    longint    err;
    out_item_t ans;
    hit = -1;
    case (it.opcode)
      OP_LOAD: begin
        if (it.joint_slot < NUM_JOINTS) begin
          sim_used[it.joint_slot]  = 1'b1;
          sim_dev[it.joint_slot]   = it.dev_id;
          sim_lo[it.joint_slot]    = it.limit_min;
          sim_hi[it.joint_slot]    = it.limit_max;
          sim_speed[it.joint_slot] = it.slew_speed;
          sim_pos[it.joint_slot]   = it.value;
          sim_tgt[it.joint_slot]   = it.value;
          sim_vel[it.joint_slot]   = '0;
          sim_mode[it.joint_slot]  = code_standby;
        end
      end
      OP_TICK: begin
        // Elapsed time saturates at one second; a zero interval is a no-op.
        dt = (it.elapsed > ONE_SECOND) ? ONE_SECOND : it.elapsed;
        if (dt != 0) begin
          for (j = 0; j < NUM_JOINTS; j++) begin
            if (sim_used[j]) begin
              if (sim_mode[j] == code_velocity) begin
                p = longint'(sim_vel[j]) * dt;
                p = clamp_to_limits(longint'(sim_pos[j]) + (p >>> FRAC_BITS), j);
                sim_pos[j] = p[31:0];
                sim_tgt[j] = p[31:0];
              end else begin
                step = (longint'(sim_speed[j]) * dt) >>> FRAC_BITS;
                err  = longint'(sim_tgt[j]) - longint'(sim_pos[j]);
                if ((err < 0 ? -err : err) <= step) begin
                  sim_pos[j] = sim_tgt[j];
                end else begin
                  p = longint'(sim_pos[j]) + (err < 0 ? -step : step);
                  sim_pos[j] = p[31:0];
                end
              end
            end
          end
        end
      end
      OP_POS, OP_VEL, OP_MODE, OP_REQ: begin
        // The lowest slot in use with a matching id is the one addressed.
        for (j = NUM_JOINTS - 1; j >= 0; j--) begin
          if (sim_used[j] && sim_dev[j] == it.dev_id) hit = j;
        end
        if (hit >= 0 && it.value_valid) begin
          case (it.opcode)
            OP_POS: begin
              p = clamp_to_limits(longint'(it.value), hit);
              sim_tgt[hit]  = p[31:0];
              sim_vel[hit]  = '0;
              sim_mode[hit] = code_position;
            end
            OP_VEL: begin
              sim_vel[hit]  = it.value;
              sim_mode[hit] = code_velocity;
            end
            OP_MODE: begin
              sim_mode[hit] = it.mode_value;
              sim_vel[hit]  = '0;
              sim_tgt[hit]  = sim_pos[hit];
            end
            default: begin
              if (it.request_code == REQ_POSITION || it.request_code == REQ_MODE) begin
                ans.answer_device   = sim_dev[hit];
                ans.answer_kind     = (it.request_code == REQ_MODE);
                ans.answer_position = (it.request_code == REQ_POSITION) ? sim_pos[hit] : '0;
                ans.answer_mode     = (it.request_code == REQ_MODE) ? sim_mode[hit] : '0;
                pending_answers = {pending_answers, ans};
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Beat builders: every field not set explicitly carries random bits, so
  // that the block is seen to ignore them.
  // --------------------------------------------------------------------------

  function automatic in_item_t scrambled_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t load_item(input logic [1:0] slot, input logic [7:0] dev,
                                         input logic signed [31:0] lo,
                                         input logic signed [31:0] hi,
                                         input logic [30:0] speed,
                                         input logic signed [31:0] start);
    in_item_t it;
    it = scrambled_item();
    it.opcode     = OP_LOAD;
    it.joint_slot = slot;
    it.dev_id     = dev;
    it.limit_min  = lo;
    it.limit_max  = hi;
    it.slew_speed = speed;
    it.value      = start;
    return it;
  endfunction

  function automatic in_item_t command_item(input logic [2:0] op, input logic [7:0] dev,
                                            input logic signed [31:0] v);
    in_item_t it;
    it = scrambled_item();
    it.opcode      = op;
    it.dev_id      = dev;
    it.value       = v;
    it.value_valid = 1'b1;
    return it;
  endfunction

  function automatic in_item_t mode_item(input logic [7:0] dev, input logic [7:0] mode);
    in_item_t it;
    it = command_item(OP_MODE, dev, $urandom);
    it.mode_value = mode;
    return it;
  endfunction

  function automatic in_item_t request_item(input logic [7:0] dev, input logic [7:0] code);
    in_item_t it;
    it = command_item(OP_REQ, dev, $urandom);
    it.request_code = code;
    return it;
  endfunction

  function automatic in_item_t tick_item(input logic [16:0] dt);
    in_item_t it;
    it = scrambled_item();
    it.opcode  = OP_TICK;
    it.elapsed = dt;
    return it;
  endfunction

  // Mostly moderate positions, with the occasional extreme or raw word.
  function automatic logic signed [31:0] random_q16();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? Q_MAX : Q_MIN;
      default: return int'($urandom_range(0, 3 * Q_HUNDRED)) - (3 * Q_HUNDRED) / 2;
    endcase
  endfunction

  // A random beat, shaped so that most commands reach a loaded joint.
  function automatic in_item_t random_command();
    in_item_t    it;
    logic [7:0]  dev;
    logic [7:0]  mode;
    logic [7:0]  code;
    logic [16:0] dt;
    logic [30:0] speed;
    int          pick;
    int          lo;
    int          hi;
    int          centre;
    int          span;
    int          spare;
    dev  = ($urandom_range(99) < 85) ? id_pool[$urandom_range(5)] : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      centre = int'($urandom_range(0, 2 * Q_HUNDRED)) - Q_HUNDRED;
      span   = $urandom_range(0, 2 * Q_HUNDRED);
      lo     = centre - span / 2;
      hi     = centre + span / 2;
      if ($urandom_range(9) == 0) begin
        spare = lo;
        lo    = hi;
        hi    = spare;
      end else if ($urandom_range(19) == 0) begin
        lo = Q_MIN;
        hi = Q_MAX;
      end
      speed = ($urandom_range(4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h40_0000));
      it = load_item(2'($urandom), dev, lo, hi, speed, random_q16());
    end else if (pick < 25) begin
      it = command_item(OP_POS, dev, random_q16());
    end else if (pick < 35) begin
      it = command_item(OP_VEL, dev, random_q16());
    end else if (pick < 45) begin
      case ($urandom_range(5))
        0:       mode = code_velocity;
        1:       mode = code_position;
        2:       mode = code_standby;
        default: mode = 8'($urandom);
      endcase
      it = mode_item(dev, mode);
    end else if (pick < 75) begin
      if ($urandom_range(9) < 8) begin
        code = $urandom_range(1) ? REQ_MODE : REQ_POSITION;
      end else begin
        code = 8'($urandom);
      end
      it = request_item(dev, code);
    end else if (pick < 97) begin
      case ($urandom_range(19))
        0, 1:    dt = '0;
        2, 3:    dt = ONE_SECOND;
        4:       dt = 17'($urandom);
        default: dt = 17'($urandom_range(1, 32'h4000));
      endcase
      it = tick_item(dt);
    end else begin
      it = scrambled_item();
      it.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    end
    // A few commands arrive with a payload that failed to decode.
    if (pick >= 10 && pick < 75 && $urandom_range(99) < 8) it.value_valid = 1'b0;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Sends one beat, after a random idle gap, and holds it until the block
  // takes it. The model sees the beat at the edge where it is accepted.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    simulate_joint_item(it);
  endtask

  // Lets the block drain: every expected answer out, then enough cycles for
  // a tick that gives no answer to finish its walk over the table.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode_code(input logic [1:0] idx, input logic [7:0] code);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VEL_CODE:  code_velocity = code;
      CFG_POS_CODE:  code_position = code;
      CFG_STBY_CODE: code_standby  = code;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_random_items(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) send_item(random_command());
    wait_for_answers();
  endtask

  // The receiver stalls at random; the percentage is set per phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Answer checking
  // --------------------------------------------------------------------------

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        note_error($sformatf("unexpected answer dev %02h kind %0d pos %08h mode %02h",
                             out_data.answer_device, out_data.answer_kind,
                             out_data.answer_position, out_data.answer_mode));
      end else begin
        expected_answer = pending_answers[0];
        pending_answers.delete(0);
        if (out_data.answer_device   !== expected_answer.answer_device   ||
            out_data.answer_kind     !== expected_answer.answer_kind     ||
            out_data.answer_position !== expected_answer.answer_position ||
            out_data.answer_mode     !== expected_answer.answer_mode) begin
          note_error($sformatf({"answer mismatch: expected dev %02h kind %0d pos %08h ",
                                "mode %02h, got dev %02h kind %0d pos %08h mode %02h"},
                               expected_answer.answer_device, expected_answer.answer_kind,
                               expected_answer.answer_position, expected_answer.answer_mode,
                               out_data.answer_device, out_data.answer_kind,
                               out_data.answer_position, out_data.answer_mode));
        end
      end
    end
  end

  // The watchdog counts cycles in which no beat moves on any channel. A
  // correct block never sits that long, even under the heaviest idling.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked beats: full-range and crossed limits, a shadowed duplicate id,
  // saturation of the elapsed time, the flooring of a negative velocity step,
  // invalid payloads, unanswered request codes, unknown ids and opcodes.
  task automatic check_directed_edges();
    in_item_t it;
    // Nothing is loaded yet, so this request finds no joint.
    send_item(request_item(8'h00, REQ_POSITION));
    send_item(load_item(2'd0, 8'h00, Q_MIN, Q_MAX, 31'h7FFF_FFFF, Q_MIN));
    send_item(load_item(2'd1, 8'hFF, -Q_ONE, Q_ONE, 31'h0000_8000, '0));
    send_item(load_item(2'd2, 8'h5A, 2 * Q_ONE, -2 * Q_ONE, '0, Q_MAX));
    // Same id as slot 2, so slot 3 is never addressed while slot 2 holds it.
    send_item(load_item(2'd3, 8'h5A, -3 * Q_ONE, 3 * Q_ONE, 31'(Q_ONE), 32'sd5));
    send_item(command_item(OP_POS, 8'hFF, Q_MAX));
    it = command_item(OP_POS, 8'hFF, Q_MIN);
    it.value_valid = 1'b0;
    send_item(it);
    send_item(tick_item(17'h0_8000));
    send_item(request_item(8'hFF, REQ_POSITION));
    send_item(tick_item(17'h1_FFFF));
    send_item(command_item(OP_POS, 8'h5A, '0));
    send_item(tick_item(ONE_SECOND));
    send_item(command_item(OP_VEL, 8'h00, Q_MAX));
    send_item(tick_item(ONE_SECOND));
    send_item(request_item(8'h00, REQ_POSITION));
    send_item(command_item(OP_VEL, 8'h00, Q_MIN));
    send_item(tick_item(17'h0_0001));
    send_item(request_item(8'h00, REQ_POSITION));
    send_item(mode_item(8'hFF, 8'hFF));
    send_item(request_item(8'hFF, REQ_MODE));
    it = request_item(8'h5A, REQ_POSITION);
    it.value_valid = 1'b0;
    send_item(it);
    send_item(request_item(8'hFF, 8'd2));
    send_item(request_item(8'hFF, 8'hFF));
    send_item(request_item(8'h33, REQ_MODE));
    it = scrambled_item();
    it.opcode = OP_SPARE_A;
    send_item(it);
    it = scrambled_item();
    it.opcode = OP_SPARE_B;
    send_item(it);
    send_item(request_item(8'h5A, REQ_POSITION));
    wait_for_answers();
  endtask

  // Random traffic under each idling pattern, with the reset mode codes.
  task automatic check_idle_phases();
    id_pool = '{8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'($urandom), 8'($urandom)};
    run_random_items(120, 0, 0);
    run_random_items(120, 70, 0);
    run_random_items(120, 0, 70);
    run_random_items(120, 35, 35);
  endtask

  // Rewrites the mode codes between bursts of traffic: extremes, codes that
  // collide with one another, and finally the reset values again.
  task automatic check_mode_codes();
    logic [7:0] code_sets [5][3];
    code_sets = '{'{8'd0,   8'd255, 8'd128},
                  '{8'd255, 8'd0,   8'd255},
                  '{8'd7,   8'd7,   8'd7},
                  '{8'd0,   8'd0,   8'd1},
                  '{8'd2,   8'd1,   8'd0}};
    // The spare index must leave every register as it was.
    write_mode_code(CFG_UNUSED, 8'hA5);
    for (int s = 0; s < 5; s++) begin
      write_mode_code(CFG_VEL_CODE,  code_sets[s][0]);
      write_mode_code(CFG_POS_CODE,  code_sets[s][1]);
      write_mode_code(CFG_STBY_CODE, code_sets[s][2]);
      run_random_items(55, (s % 2) ? 35 : 0, (s % 3 == 1) ? 70 : 35);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_directed_edges();
    check_idle_phases();
    check_mode_codes();
    if (pending_answers.size() != 0) begin
      note_error($sformatf("%0d expected answers never arrived", pending_answers.size()));
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
